FILE: src/tcc_pkg.sv
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MILLIS_W = 27;
	localparam int unsigned WDAY_W   = 3;
	localparam int unsigned TICK_W   = 32;
	localparam int unsigned STEP_W   = 8;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [MILLIS_W-1:0] DAY_MS      = 27'd86400000;
	localparam logic [YEAR_W-1:0]   YEAR_MAX    = 12'd4095;
	localparam logic [YEAR_W-1:0]   EPOCH_YEAR  = 12'd1980;
	localparam logic [YEAR_W-1:0]   RESET_YEAR  = 12'd1986;
	localparam logic [MONTH_W-1:0]  RESET_MONTH = 4'd4;
	localparam logic [DAY_W-1:0]    RESET_DAY   = 5'd8;
	localparam logic [STEP_W-1:0]   RESET_NORMAL_STEP    = 8'd15;
	localparam logic [STEP_W-1:0]   RESET_CORRECTED_STEP = 8'd20;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STEP    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CORRECTED_STEP = 1'b1;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	typedef struct packed {
		logic                command;
		logic [YEAR_W-1:0]   set_year;
		logic [MONTH_W-1:0]  set_month;
		logic [DAY_W-1:0]    set_day;
		logic [MILLIS_W-1:0] set_millis;
	} cmd_item_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   year_now;
		logic [MONTH_W-1:0]  month_now;
		logic [DAY_W-1:0]    day_now;
		logic [MILLIS_W-1:0] millis_now;
		logic [WDAY_W-1:0]   weekday_now;
		logic [TICK_W-1:0]   ticks_total;
	} res_item_t;

	function automatic logic [DAY_W-1:0] month_len(
		input logic [MONTH_W-1:0] month,
		input logic [YEAR_W-1:0]  year
	);
		logic century;
		logic quad;
		logic [DAY_W-1:0] n;
		century = 1'b0;
		quad    = 1'b0;
		for (int k = 0; k <= 40; k++) begin
			if (year == YEAR_W'(k * 100)) century = 1'b1;
		end
		for (int k = 0; k <= 10; k++) begin
			if (year == YEAR_W'(k * 400)) quad = 1'b1;
		end
		if (month == 4'd2) begin
			n = 5'd28 + {4'd0, (year[1:0] == 2'd0)} - {4'd0, century} + {4'd0, quad};
		end else begin
			n = 5'd30 + {4'd0, ((month > 4'd7) ^ month[0])};
		end
		return n;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
		logic [8:0] d;
		case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [WDAY_W-1:0] mod7(input logic [11:0] v);
		logic [4:0] s;
		logic [3:0] t;
		s = {2'd0, v[2:0]} + {2'd0, v[5:3]} + {2'd0, v[8:6]} + {2'd0, v[11:9]};
		t = {1'b0, s[2:0]} + {2'd0, s[4:3]};
		if (t >= 4'd7) t = t - 4'd7;
		return t[2:0];
	endfunction

	function automatic logic [WDAY_W-1:0] weekday(
		input logic [YEAR_W-1:0]  year,
		input logic [MONTH_W-1:0] month,
		input logic [DAY_W-1:0]   day
	);
		logic [11:0] y;
		logic [11:0] sum;
		logic [WDAY_W-1:0] w;
		y = year - EPOCH_YEAR;
		sum = y + ((y + 12'd3) >> 2) + {3'd0, days_before(month)} + {7'd0, day} + 12'd1
			+ {11'd0, (y[1:0] == 2'd0) && (month > 4'd2)};
		if (year < EPOCH_YEAR || month < 4'd1 || month > 4'd12) begin
			w = '0;
		end else begin
			w = mod7(sum);
		end
		return w;
	endfunction

endpackage

FILE: src/tcc_if.sv
`timescale 1ns / 1ps

interface tcc_cmd_if import tcc_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tcc_res_if import tcc_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/tick_calendar_clock_unit.sv
`timescale 1ns / 1ps
// An accepted cmd beat updates the state registers and valid_s1; the res stage then registers its snapshot.
// Throughput: one beat per cycle; cmd.ready drops only while res is stalled and full.
// State is updated in the accept cycle, weekday is formed in the result stage.
// Reset (arst_n low, async): 1986-04-08 00:00:00.000, tick count 0,
// steps 15 ms and 20 ms, pipeline empty.
module tick_calendar_clock_unit import tcc_pkg::*; #(
	parameter int unsigned CORRECTION_PERIOD_LOG2 = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [STEP_W-1:0]    cfg_data,
	tcc_cmd_if.sink              cmd,
	tcc_res_if.source            res
);

	logic [STEP_W-1:0]   normal_step_q;
	logic [STEP_W-1:0]   corrected_step_q;
	logic [MILLIS_W-1:0] millis_q;
	logic [DAY_W-1:0]    day_q;
	logic [MONTH_W-1:0]  month_q;
	logic [YEAR_W-1:0]   year_q;
	logic [TICK_W-1:0]   tick_q;
	logic                valid_s1;
	logic                res_valid_q;
	res_item_t           res_data_q;

	logic                ready_s2;
	logic                ready_s1;
	logic                accept;
	logic [TICK_W-1:0]   tick_inc;
	logic [STEP_W-1:0]   step;
	logic [MILLIS_W-1:0] msum;
	logic [MILLIS_W-1:0] set_ms;
	logic [DAY_W:0]      day_inc;
	logic [MONTH_W:0]    month_inc;
	logic                roll;
	logic [MILLIS_W-1:0] millis_d;
	logic [DAY_W-1:0]    day_d;
	logic [MONTH_W-1:0]  month_d;
	logic [YEAR_W-1:0]   year_d;
	logic [TICK_W-1:0]   tick_d;

	assign ready_s2  = !res_valid_q || res.ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign cmd.ready = ready_s1;
	assign accept    = cmd.valid && ready_s1;
	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	always_comb begin
		tick_inc  = tick_q + 1'b1;
		step      = (|tick_inc[CORRECTION_PERIOD_LOG2-1:0]) ? normal_step_q : corrected_step_q;
		msum      = millis_q + MILLIS_W'(step);
		set_ms    = (cmd.data.set_millis >= DAY_MS) ? cmd.data.set_millis - DAY_MS
			: cmd.data.set_millis;
		day_inc   = {1'b0, day_q} + 1'b1;
		month_inc = {1'b0, month_q} + 1'b1;
		roll      = (day_inc > 6'd28) && (day_inc > {1'b0, month_len(month_q, year_q)});

		millis_d = millis_q;
		day_d    = day_q;
		month_d  = month_q;
		year_d   = year_q;
		tick_d   = tick_q;
		if (cmd.data.command == CMD_SET) begin
			millis_d = set_ms;
			day_d    = cmd.data.set_day;
			month_d  = cmd.data.set_month;
			year_d   = cmd.data.set_year;
		end else begin
			tick_d = tick_inc;
			if (msum >= DAY_MS) begin
				millis_d = msum - DAY_MS;
				if (roll) begin
					day_d = 5'd1;
					if (month_inc > 5'd12) begin
						month_d = 4'd1;
						if (year_q < YEAR_MAX) year_d = year_q + 1'b1;
					end else begin
						month_d = month_inc[MONTH_W-1:0];
					end
				end else begin
					day_d = day_inc[DAY_W-1:0];
				end
			end else begin
				millis_d = msum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_step_q    <= RESET_NORMAL_STEP;
			corrected_step_q <= RESET_CORRECTED_STEP;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NORMAL_STEP:    normal_step_q <= cfg_data;
				REG_CORRECTED_STEP: corrected_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			millis_q <= '0;
			day_q    <= RESET_DAY;
			month_q  <= RESET_MONTH;
			year_q   <= RESET_YEAR;
			tick_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				millis_q <= millis_d;
				day_q    <= day_d;
				month_q  <= month_d;
				year_q   <= year_d;
				tick_q   <= tick_d;
			end
			if (ready_s1) valid_s1 <= cmd.valid;
		end
	end

	// state registers hold the snapshot of the beat in stage one until it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ready_s2) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			res_data_q.year_now    <= year_q;
			res_data_q.month_now   <= month_q;
			res_data_q.day_now     <= day_q;
			res_data_q.millis_now  <= millis_q;
			res_data_q.weekday_now <= weekday(year_q, month_q, day_q);
			res_data_q.ticks_total <= tick_q;
		end
	end

endmodule

FILE: src/tcc_checker.sv
`timescale 1ns / 1ps

module tcc_checker import tcc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_ready,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("res beat changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("cmd stalled without res backpressure");

	a_res_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> ##1 res_valid)
		else $error("accepted cmd beat produced no res beat");

	a_millis_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.millis_now < DAY_MS)
		else $error("millis past one day");

	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.weekday_now <= 3'd6
			&& (res_data.year_now >= EPOCH_YEAR || res_data.weekday_now == 3'd0))
		else $error("weekday out of range");

endmodule

bind tick_calendar_clock_unit tcc_checker u_tcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

FILE: verif/tick_calendar_clock_unit_test.sv
`timescale 1ns / 1ps

module tick_calendar_clock_unit_test;
	import tcc_pkg::*;

	localparam int unsigned CORR_LOG2   = 3;
	localparam logic [31:0] PERIOD_MASK = (32'd1 << CORR_LOG2) - 32'd1;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DAYS_AHEAD [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	typedef struct {
		cmd_item_t beat;
		bit        pinned;
		res_item_t want;
	} probe_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [STEP_W-1:0]    cfg_data;

	tcc_cmd_if cmd_ch ();
	tcc_res_if res_ch ();

	tick_calendar_clock_unit #(
		.CORRECTION_PERIOD_LOG2(CORR_LOG2)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	// calendar shadow
	int unsigned       cal_year;
	int unsigned       cal_month;
	int unsigned       cal_day;
	int unsigned       cal_ms;
	logic [31:0]       cal_ticks;
	logic [STEP_W-1:0] step_normal;
	logic [STEP_W-1:0] step_corr;

	res_item_t   calendar_due [$];
	probe_t      probes [$];
	int unsigned beats_in;
	int unsigned beats_sent;
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned calm_left;
	bit          quiet;
	bit          hold_req;
	int unsigned n_sets;
	int unsigned n_ticks;
	int unsigned n_rolls;
	int unsigned n_caps;
	int unsigned n_settings;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		int unsigned n;
		if (m == 2) begin
			n = 28;
			if (y % 4 == 0) n++;
			if (y % 100 == 0) n--;
			if (y % 400 == 0) n++;
			return n;
		end
		return 30 + ((m > 7) ^ (m & 1));
	endfunction

	function automatic logic [WDAY_W-1:0] day_of_week(int unsigned y, int unsigned m,
			int unsigned d);
		int unsigned yy;
		int unsigned sum;
		if (y < EPOCH_YEAR || m < 1 || m > 12) return '0;
		yy = y - EPOCH_YEAR;
		sum = 365 * yy + (yy + 3) / 4 + DAYS_AHEAD[m - 1] + d + 1;
		if (yy % 4 == 0 && m > 2) sum++;
		return WDAY_W'(sum % 7);
	endfunction

	function automatic res_item_t clock_advance(input cmd_item_t beat);
		int unsigned ms;
		int unsigned next_day;
		res_item_t r;
		if (beat.command == CMD_SET) begin
			ms = beat.set_millis;
			if (ms >= DAY_MS) ms -= DAY_MS;
			cal_year  = beat.set_year;
			cal_month = beat.set_month;
			cal_day   = beat.set_day;
			cal_ms    = ms;
			n_sets++;
		end else begin
			cal_ticks = cal_ticks + 32'd1;
			cal_ms += ((cal_ticks & PERIOD_MASK) != 0) ? step_normal : step_corr;
			if (cal_ms >= DAY_MS) begin
				cal_ms -= DAY_MS;
				n_rolls++;
				next_day = cal_day + 1;
				if (next_day > 28 && next_day > days_in_month(cal_month, cal_year)) begin
					next_day = 1;
					cal_month++;
					if (cal_month > 12) begin
						cal_month = 1;
						if (cal_year < YEAR_MAX) cal_year++;
						else n_caps++;
					end
				end
				cal_day = next_day & 31;
			end
			n_ticks++;
		end
		r.year_now    = YEAR_W'(cal_year);
		r.month_now   = MONTH_W'(cal_month);
		r.day_now     = DAY_W'(cal_day);
		r.millis_now  = MILLIS_W'(cal_ms);
		r.weekday_now = day_of_week(cal_year, cal_month, cal_day);
		r.ticks_total = cal_ticks;
		return r;
	endfunction

	function automatic cmd_item_t calendar_beat(logic c, int y, int m, int d, int ms);
		cmd_item_t it;
		it.command    = c;
		it.set_year   = YEAR_W'(y);
		it.set_month  = MONTH_W'(m);
		it.set_day    = DAY_W'(d);
		it.set_millis = MILLIS_W'(ms);
		return it;
	endfunction

	function automatic cmd_item_t scrambled_beat(logic c);
		logic [63:0] raw;
		cmd_item_t it;
		raw = {$urandom, $urandom};
		it = raw[$bits(cmd_item_t)-1:0];
		it.command = c;
		return it;
	endfunction

	// land just before midnight on the last or second-last day of a month
	function automatic cmd_item_t boundary_set();
		int y;
		int m;
		int len;
		case ($urandom_range(0, 7))
			0: y = 1900;
			1: y = 2000;
			2: y = 2100;
			3: y = YEAR_MAX - $urandom_range(0, 1);
			4: y = EPOCH_YEAR - 1;
			5, 6: y = $urandom_range(1980, 2100);
			default: y = $urandom_range(0, 4095);
		endcase
		if ($urandom_range(0, 2) == 0) m = 12;
		else if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 15);
		else m = $urandom_range(1, 12);
		len = days_in_month(m, y);
		return calendar_beat(CMD_SET, y, m, len - $urandom_range(0, 1),
			DAY_MS - $urandom_range(1, 4000));
	endfunction

	task automatic flag_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_item_t got;
		res_item_t want;
		if (!arst_n) begin
			cal_year    = RESET_YEAR;
			cal_month   = RESET_MONTH;
			cal_day     = RESET_DAY;
			cal_ms      = 0;
			cal_ticks   = '0;
			step_normal = RESET_NORMAL_STEP;
			step_corr   = RESET_CORRECTED_STEP;
			beats_in    = 0;
			calendar_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_NORMAL_STEP:    step_normal = cfg_data;
					REG_CORRECTED_STEP: step_corr = cfg_data;
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (calendar_due.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %0d-%0d-%0d %0d ms",
						$time, got.year_now, got.month_now, got.day_now, got.millis_now);
					mismatches++;
				end else begin
					want = calendar_due.pop_front();
					flag_field("year", 32'(want.year_now), 32'(got.year_now));
					flag_field("month", 32'(want.month_now), 32'(got.month_now));
					flag_field("day", 32'(want.day_now), 32'(got.day_now));
					flag_field("millis", 32'(want.millis_now), 32'(got.millis_now));
					flag_field("weekday", 32'(want.weekday_now), 32'(got.weekday_now));
					flag_field("ticks", want.ticks_total, got.ticks_total);
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = clock_advance(cmd_ch.data);
				if (beats_in < probes.size() && probes[beats_in].pinned)
					want = probes[beats_in].want;
				calendar_due.push_back(want);
				beats_in++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, calendar_due.size());
			$display("tick_calendar_clock_unit_test: errors");
			$finish;
		end
	end

	// result side: random stalls, one long hold on request
	initial begin
		int unsigned span;
		logic level;
		res_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				level = 1'b0;
				span = LONG_HOLD;
			end else if (quiet) begin
				level = 1'b1;
				span = 1;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						level = 1'b0;
						span = $urandom_range(1, 16);
					end
					9: begin
						level = 1'b1;
						span = $urandom_range(40, 120);
					end
					default: begin
						level = 1'b1;
						span = $urandom_range(1, 12);
					end
				endcase
			end
			res_ch.ready <= level;
			repeat (span) @(posedge clk);
		end
	end

	task automatic offer(cmd_item_t it);
		if (calm_left > 0) begin
			calm_left--;
		end else if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(16, 64);
		end else if ($urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= it;
		do @(posedge clk); while (!cmd_ch.ready);
		beats_sent++;
	endtask

	task automatic settle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (calendar_due.size() != 0);
	endtask

	task automatic load_steps(logic [STEP_W-1:0] normal, logic [STEP_W-1:0] corrected);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_NORMAL_STEP;
		cfg_data <= normal;
		@(posedge clk);
		cfg_idx  <= REG_CORRECTED_STEP;
		cfg_data <= corrected;
		@(posedge clk);
		cfg_we   <= 1'b0;
		n_settings++;
	endtask

	task automatic make_traffic(int unsigned n);
		int unsigned goal;
		int unsigned k;
		goal = beats_sent + n;
		while (beats_sent < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					offer(boundary_set());
					k = $urandom_range(1, 40);
					repeat (k) offer(scrambled_beat(CMD_TICK));
				end
				6, 7: begin
					k = $urandom_range(1, 30);
					repeat (k) offer(scrambled_beat(CMD_TICK));
				end
				default: offer(scrambled_beat(CMD_SET));
			endcase
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_NORMAL_STEP;
		cfg_data     = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		calm_left    = 0;

		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b1,
			'{12'd1986, 4'd4, 5'd8, 27'd15, 3'd2, 32'd1}});
		probes.push_back('{calendar_beat(CMD_SET, 1979, 12, 31, 86399990), 1'b1,
			'{12'd1979, 4'd12, 5'd31, 27'd86399990, 3'd0, 32'd1}});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b1,
			'{12'd1980, 4'd1, 5'd1, 27'd5, 3'd2, 32'd2}});
		probes.push_back('{calendar_beat(CMD_SET, 4095, 12, 31, 86399999), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 0, 2, 28, 134217727), 1'b1,
			'{12'd0, 4'd2, 5'd28, 27'd47817727, 3'd0, 32'd3}});
		probes.push_back('{calendar_beat(CMD_SET, 2000, 2, 28, 86399999), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 1900, 2, 28, 86399999), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 2024, 4, 30, 86399999), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 2024, 6, 31, 86399999), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 2024, 0, 30, 86399995), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 2024, 15, 30, 86399999), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 2025, 1, 0, DAY_MS), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 4095, 15, 31, 134217727), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_SET, 2023, 2, 28, 86399999), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});
		probes.push_back('{calendar_beat(CMD_TICK, 0, 0, 0, 0), 1'b0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (probes[i]) offer(probes[i].beat);
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: load_steps(8'd0, 8'd255);
				1: load_steps(8'd255, 8'd0);
				2: begin
					load_steps(8'd255, 8'd255);
					// keep offering while the result side holds off
					calm_left = 100000;
					hold_req = 1'b1;
				end
				3: begin
					load_steps(STEP_W'($urandom), STEP_W'($urandom));
					calm_left = 0;
				end
				4: load_steps(8'd0, 8'd0);
				default: begin
					load_steps(RESET_NORMAL_STEP, RESET_CORRECTED_STEP);
					quiet = 1'b1;
					calm_left = 32'h4000_0000;
				end
			endcase
			make_traffic(280);
			settle();
		end
		repeat (8) @(posedge clk);

		$display("Run covered %0d tick beats and %0d set beats under %0d step settings,",
			n_ticks, n_sets, n_settings);
		$display("with %0d midnight crossings, %0d of them at the year ceiling.",
			n_rolls, n_caps);
		if (mismatches == 0) begin
			$display("tick_calendar_clock_unit_test: clean");
		end else begin
			$display("tick_calendar_clock_unit_test: errors");
		end
		$finish;
	end

endmodule
